### rtl/set_assoc_lru_cache_lookup_top_assert.svh
// Assertion macros for the cache lookup block.
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_TOP_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_TOP_ASSERT_SVH

// The property must hold in the same cycle as its condition.
`define SALC_ASSERT_IMPLY(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("cache lookup: same-cycle property violated");

// The property must hold in the cycle after its condition.
`define SALC_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("cache lookup: next-cycle property violated");

`endif

### rtl/salc_pkg.sv
`default_nettype none

package salc_pkg;

    localparam int ACTION_W  = 2;
    localparam int RAW_SET_W = 7;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [1:0]          reg_index_t;

    localparam action_t ACT_LOAD   = 2'd0;
    localparam action_t ACT_STORE  = 2'd1;
    localparam action_t ACT_MODIFY = 2'd2;

    localparam reg_index_t REG_SET_BITS    = 2'd0;
    localparam reg_index_t REG_BLOCK_BITS  = 2'd1;
    localparam reg_index_t REG_WAYS_IN_USE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_MOD,
        ST_READ,
        ST_SCAN,
        ST_UPDATE
    } state_t;

endpackage

`default_nettype wire

### rtl/set_assoc_lru_cache_lookup_top.sv
`default_nettype none
`include "set_assoc_lru_cache_lookup_top_assert.svh"

// Set-associative cache tag lookup with least-recently-used replacement. Each request
// carries a load, store or modify on a byte address; a load or a store gives one result,
// a modify gives two (the second flagged last_of_item), and action code 3 is taken and
// dropped without a result. One shared tag comparator walks the ways of a set one per
// cycle. An access goes through an address split, a set fold, a row read, a scan of the
// ways in use and a write-back step; the fold subtracts MAX_SETS from a set index of
// MAX_SETS or more until it fits the store (no step when 2**set_bits <= MAX_SETS), and
// a modify repeats the row read, scan and write-back. The set row is read from a
// single-port memory with a registered read, and a result waiting on the output register
// stalls only the final write-back step. After reset a clearing pass empties the tag store
// before the first request is accepted; configuration writes are taken at any time.
module set_assoc_lru_cache_lookup_top #(
    parameter int MAX_SETS   = 64,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 64
) (
    input  wire                             aclk,
    input  wire                             aresetn,

    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [salc_pkg::PADDR_W-1:0]    paddr,
    input  wire  [salc_pkg::PDATA_W-1:0]    pwdata,
    output logic [salc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,

    input  wire                             s_valid,
    output logic                            s_ready,
    input  salc_pkg::action_t               s_action,
    input  wire  [ADDR_WIDTH-1:0]           s_address,

    output logic                            m_valid,
    input  wire                             m_ready,
    output logic                            m_was_hit,
    output logic                            m_was_miss,
    output logic                            m_was_evict,
    output logic                            m_last_of_item,
    output logic [31:0]                     m_hit_total,
    output logic [31:0]                     m_miss_total,
    output logic [31:0]                     m_evict_total
);

    import salc_pkg::*;

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);

    localparam logic [SET_W-1:0]  LAST_SET = SET_W'(MAX_SETS - 1);
    localparam logic [12:0]       SETS_C   = 13'(MAX_SETS);
    localparam logic [5:0]        WAYS_C   = 6'(MAX_WAYS);
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    // Configuration registers.
    logic [2:0] set_bits_reg;
    logic [5:0] block_bits_reg;
    logic [3:0] ways_in_use_reg;

    // Sequencer and control state.
    state_t           state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg;
    logic             more_reg;
    logic [31:0]      hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;
    logic [31:0]      hit_cnt_next, miss_cnt_next, evict_cnt_next;
    logic             m_valid_reg;
    logic             m_was_hit_reg, m_was_miss_reg, m_was_evict_reg, m_last_reg;

    // Access datapath.
    logic [ADDR_WIDTH-1:0] addr_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic [RAW_SET_W-1:0]  set_raw_reg;
    logic [WAY_W-1:0]      way_reg;
    logic                  hit_found_reg, free_found_reg;
    logic [WAY_W-1:0]      hit_pos_reg, free_pos_reg, best_pos_reg;
    logic [RANK_W-1:0]     hit_rank_reg, best_rank_reg;

    // Set store, one row per set, and its registered read data.
    logic [MAX_WAYS-1:0]                    valid_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]    tag_mem   [MAX_SETS];
    logic [MAX_WAYS-1:0][RANK_W-1:0]        rank_mem  [MAX_SETS];
    logic [MAX_WAYS-1:0]                    rd_valid_reg;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]    rd_tag_reg;
    logic [MAX_WAYS-1:0][RANK_W-1:0]        rd_rank_reg;

    // Combinational signals.
    logic                               cfg_write;
    logic                               act_ok;
    logic [ADDR_WIDTH-1:0]              set_shift;
    logic [RAW_SET_W-1:0]               set_mask;
    logic [6:0]                         tag_shamt;
    logic [12:0]                        raw_ext;
    logic                               set_ge;
    logic [SET_W-1:0]                   set_idx;
    logic [5:0]                         ways_ext, ways_eff6;
    logic [WCNT_W-1:0]                  ways_eff;
    logic                               way_last;
    logic                               cur_valid;
    logic [ADDR_WIDTH-1:0]              cur_tag;
    logic [RANK_W-1:0]                  cur_rank;
    logic                               mem_re, clr_we, upd_go, mem_we;
    logic [SET_W-1:0]                   wr_addr;
    logic [WAY_W-1:0]                   pos_sel;
    logic                               touch_valid;
    logic [RANK_W-1:0]                  old_rank;
    logic                               evict_now;
    logic [MAX_WAYS-1:0]                new_valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] new_tag;
    logic [MAX_WAYS-1:0][RANK_W-1:0]    new_rank;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_SET_BITS:    prdata = {29'd0, set_bits_reg};
            REG_BLOCK_BITS:  prdata = {26'd0, block_bits_reg};
            REG_WAYS_IN_USE: prdata = {28'd0, ways_in_use_reg};
            default:         prdata = '0;
        endcase
    end

    // Address split, set folding and associativity clamp.
    assign act_ok    = (s_action == ACT_LOAD) || (s_action == ACT_STORE) ||
                       (s_action == ACT_MODIFY);
    assign set_shift = addr_reg >> block_bits_reg;
    assign set_mask  = (RAW_SET_W'(1) << set_bits_reg) - RAW_SET_W'(1);
    assign tag_shamt = {4'd0, set_bits_reg} + {1'b0, block_bits_reg};
    assign raw_ext   = {6'd0, set_raw_reg};
    assign set_ge    = raw_ext >= SETS_C;
    assign set_idx   = SET_W'(set_raw_reg);

    assign ways_ext  = {2'd0, ways_in_use_reg};
    assign ways_eff6 = (ways_ext == 6'd0) ? 6'd1 : ((ways_ext > WAYS_C) ? WAYS_C : ways_ext);
    assign ways_eff  = WCNT_W'(ways_eff6);
    assign way_last  = (WCNT_W'(way_reg) + WCNT_W'(1)) == ways_eff;

    // The shared comparator looks at one way of the row per cycle.
    assign cur_valid = rd_valid_reg[way_reg];
    assign cur_tag   = rd_tag_reg[way_reg];
    assign cur_rank  = rd_rank_reg[way_reg];

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_cnt_reg == LAST_SET) state_next = ST_IDLE;
            ST_IDLE:   if (s_valid && act_ok) state_next = ST_SPLIT;
            ST_SPLIT:  state_next = ST_MOD;
            ST_MOD:    if (!set_ge) state_next = ST_READ;
            ST_READ:   state_next = ST_SCAN;
            ST_SCAN:   if (way_last) state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (upd_go) begin
                    state_next = more_reg ? ST_READ : ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        mem_re  = (state_reg == ST_READ);
        clr_we  = (state_reg == ST_CLEAR);
        upd_go  = (state_reg == ST_UPDATE) && (!m_valid_reg || m_ready);
        mem_we  = clr_we || upd_go;
        wr_addr = clr_we ? clr_cnt_reg : set_idx;
    end

    // Replacement choice and the new row contents.
    always_comb begin
        pos_sel     = hit_found_reg ? hit_pos_reg :
                      (free_found_reg ? free_pos_reg : best_pos_reg);
        touch_valid = hit_found_reg || !free_found_reg;
        old_rank    = hit_found_reg ? hit_rank_reg : best_rank_reg;
        evict_now   = !hit_found_reg && !free_found_reg;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (WAY_W'(j) == pos_sel) begin
                new_valid[j] = 1'b1;
                new_tag[j]   = hit_found_reg ? rd_tag_reg[j] : tag_reg;
                new_rank[j]  = '0;
            end else begin
                new_valid[j] = rd_valid_reg[j];
                new_tag[j]   = rd_tag_reg[j];
                if ((WCNT_W'(j) < ways_eff) && rd_valid_reg[j] &&
                    (!touch_valid || (rd_rank_reg[j] < old_rank)) &&
                    (rd_rank_reg[j] < RANK_MAX)) begin
                    new_rank[j] = rd_rank_reg[j] + RANK_W'(1);
                end else begin
                    new_rank[j] = rd_rank_reg[j];
                end
            end
        end
    end

    // Saturating counters.
    always_comb begin
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        if (hit_found_reg) begin
            if (hit_cnt_reg != 32'hFFFF_FFFF) hit_cnt_next = hit_cnt_reg + 32'd1;
        end else begin
            if (miss_cnt_reg != 32'hFFFF_FFFF) miss_cnt_next = miss_cnt_reg + 32'd1;
            if (evict_now && (evict_cnt_reg != 32'hFFFF_FFFF)) begin
                evict_cnt_next = evict_cnt_reg + 32'd1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            more_reg        <= 1'b0;
            hit_cnt_reg     <= '0;
            miss_cnt_reg    <= '0;
            evict_cnt_reg   <= '0;
            m_valid_reg     <= 1'b0;
            set_bits_reg    <= 3'd0;
            block_bits_reg  <= 6'd0;
            ways_in_use_reg <= 4'd1;
        end else begin
            state_reg <= state_next;
            if (clr_we) clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            if (s_valid && s_ready) more_reg <= (s_action == ACT_MODIFY);
            else if (upd_go) more_reg <= 1'b0;
            if (upd_go) begin
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
            if (cfg_write) begin
                unique case (paddr[3:2])
                    REG_SET_BITS:    set_bits_reg    <= pwdata[2:0];
                    REG_BLOCK_BITS:  block_bits_reg  <= pwdata[5:0];
                    REG_WAYS_IN_USE: ways_in_use_reg <= pwdata[3:0];
                    default:         ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) addr_reg <= s_address;
        if (state_reg == ST_SPLIT) begin
            set_raw_reg <= set_shift[RAW_SET_W-1:0] & set_mask;
            tag_reg     <= addr_reg >> tag_shamt;
        end else if ((state_reg == ST_MOD) && set_ge) begin
            set_raw_reg <= RAW_SET_W'(raw_ext - SETS_C);
        end
        if (mem_re) begin
            way_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            hit_pos_reg    <= '0;
            free_pos_reg   <= '0;
            best_pos_reg   <= '0;
            hit_rank_reg   <= '0;
            best_rank_reg  <= '0;
        end else if (state_reg == ST_SCAN) begin
            way_reg <= way_reg + WAY_W'(1);
            if (!hit_found_reg && cur_valid && (cur_tag == tag_reg)) begin
                hit_found_reg <= 1'b1;
                hit_pos_reg   <= way_reg;
                hit_rank_reg  <= cur_rank;
            end
            if (!free_found_reg && !cur_valid) begin
                free_found_reg <= 1'b1;
                free_pos_reg   <= way_reg;
            end
            if (cur_rank > best_rank_reg) begin
                best_rank_reg <= cur_rank;
                best_pos_reg  <= way_reg;
            end
        end
        if (upd_go) begin
            m_was_hit_reg   <= hit_found_reg;
            m_was_miss_reg  <= !hit_found_reg;
            m_was_evict_reg <= evict_now;
            m_last_reg      <= !more_reg;
        end
    end

    // Set store.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            valid_mem[wr_addr] <= clr_we ? '0 : new_valid;
            tag_mem[wr_addr]   <= clr_we ? '0 : new_tag;
            rank_mem[wr_addr]  <= clr_we ? '0 : new_rank;
        end
        if (mem_re) begin
            rd_valid_reg <= valid_mem[set_idx];
            rd_tag_reg   <= tag_mem[set_idx];
            rd_rank_reg  <= rank_mem[set_idx];
        end
    end

    // Result port; the totals are the counters, which change only when a result loads.
    assign m_valid        = m_valid_reg;
    assign m_was_hit      = m_was_hit_reg;
    assign m_was_miss     = m_was_miss_reg;
    assign m_was_evict    = m_was_evict_reg;
    assign m_last_of_item = m_last_reg;
    assign m_hit_total    = hit_cnt_reg;
    assign m_miss_total   = miss_cnt_reg;
    assign m_evict_total  = evict_cnt_reg;

    `SALC_ASSERT_IMPLY(a_evict_is_miss, m_valid_reg && m_was_evict_reg, m_was_miss_reg && !m_was_hit_reg)
    `SALC_ASSERT_IMPLY(a_evict_le_miss, 1'b1, evict_cnt_reg <= miss_cnt_reg)
    `SALC_ASSERT_NEXT(a_hit_cnt_mono, 1'b1, hit_cnt_reg >= $past(hit_cnt_reg))
    `SALC_ASSERT_IMPLY(a_modify_busy, m_valid_reg && !m_last_reg, !s_ready)

endmodule

`default_nettype wire
